// ===== hw/rtl/lsb32_pkg.sv =====
// ----------------------------------------------------------------------------
// lsb32_pkg
// Types, character codes and the control store of the segment text encoder.
// ----------------------------------------------------------------------------
package lsb32_pkg;

  // ASCII codes of the fixed characters.
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_SPACE  = 8'h20;
  localparam logic [7:0] CHAR_COMMA  = 8'h2C;

  // Bits of one base 32 digit and the number of coordinates of a segment.
  localparam int unsigned DIGIT_BITS = 5;
  localparam int unsigned NUM_COORDS = 4;

  // Datapath operations of one step.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_LOAD,
    OP_SKIP,
    OP_DIGIT,
    OP_NEXT
  } op_e;

  // Character that a step sends out.
  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_MINUS,
    EMIT_DIGIT,
    EMIT_SPACE,
    EMIT_COMMA
  } emit_e;

  // Jump conditions; when false the step counter moves on by one.
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_POSITIVE,
    COND_SKIP_MORE,
    COND_DIGIT_MORE,
    COND_LAST_COORD
  } cond_e;

  typedef logic [3:0] step_t;

  // Step addresses of the program.
  localparam step_t STEP_IDLE  = 4'd0;
  localparam step_t STEP_LOAD  = 4'd1;
  localparam step_t STEP_SIGN  = 4'd2;
  localparam step_t STEP_MINUS = 4'd3;
  localparam step_t STEP_SKIP  = 4'd4;
  localparam step_t STEP_DIGIT = 4'd5;
  localparam step_t STEP_SEP   = 4'd6;
  localparam step_t STEP_SPACE = 4'd7;
  localparam step_t STEP_COMMA = 4'd8;

  // One control word.
  typedef struct packed {
    op_e   op;
    emit_e emit;
    cond_e cond;
    step_t target;
  } ucode_t;

  // Status flags that the digit unit returns to the sequencer.
  typedef struct packed {
    logic neg;
    logic skip_more;
    logic digit_more;
  } digit_status_t;

  // The control store.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t word;
    unique case (step)
      STEP_IDLE:  word = '{op: OP_ACCEPT, emit: EMIT_NONE,  cond: COND_NO_INPUT,
                           target: STEP_IDLE};
      STEP_LOAD:  word = '{op: OP_LOAD,   emit: EMIT_NONE,  cond: COND_NEVER,
                           target: STEP_IDLE};
      STEP_SIGN:  word = '{op: OP_NONE,   emit: EMIT_NONE,  cond: COND_POSITIVE,
                           target: STEP_SKIP};
      STEP_MINUS: word = '{op: OP_NONE,   emit: EMIT_MINUS, cond: COND_NEVER,
                           target: STEP_IDLE};
      STEP_SKIP:  word = '{op: OP_SKIP,   emit: EMIT_NONE,  cond: COND_SKIP_MORE,
                           target: STEP_SKIP};
      STEP_DIGIT: word = '{op: OP_DIGIT,  emit: EMIT_DIGIT, cond: COND_DIGIT_MORE,
                           target: STEP_DIGIT};
      STEP_SEP:   word = '{op: OP_NONE,   emit: EMIT_NONE,  cond: COND_LAST_COORD,
                           target: STEP_COMMA};
      STEP_SPACE: word = '{op: OP_NEXT,   emit: EMIT_SPACE, cond: COND_ALWAYS,
                           target: STEP_LOAD};
      STEP_COMMA: word = '{op: OP_NONE,   emit: EMIT_COMMA, cond: COND_ALWAYS,
                           target: STEP_IDLE};
      default:    word = '{op: OP_NONE,   emit: EMIT_NONE,  cond: COND_ALWAYS,
                           target: STEP_IDLE};
    endcase
    return word;
  endfunction

  // ASCII form of one base 32 digit: 0-9 then a-v.
  function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] digit);
    logic [7:0] wide;
    wide = {3'b000, digit};
    if (digit < 5'd10) begin
      return CHAR_ZERO + wide;
    end
    return CHAR_LOWER_A + wide - 8'd10;
  endfunction

endpackage

// ===== hw/rtl/lsb32_if.sv =====
// ----------------------------------------------------------------------------
// lsb32_if
// Valid/ready channels of the encoder: segment words in, character words out.
// ----------------------------------------------------------------------------
interface lsb32_seg_if #(
  parameter int unsigned COORD_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] start_x;
  logic signed [COORD_WIDTH-1:0] start_y;
  logic signed [COORD_WIDTH-1:0] end_x;
  logic signed [COORD_WIDTH-1:0] end_y;

  modport source (output valid, start_x, start_y, end_x, end_y, input ready);
  modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsb32_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_char;
  logic       last_char;

  modport source (output valid, text_char, last_char, input ready);
  modport sink   (input valid, text_char, last_char, output ready);
endinterface

// ===== hw/rtl/lsb32_digit_unit.sv =====
// ----------------------------------------------------------------------------
// lsb32_digit_unit
// Magnitude register that shifts out base 32 digits, most significant first.
// ----------------------------------------------------------------------------
module lsb32_digit_unit
  import lsb32_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  op_e                    op_i,
  input  logic [COORD_WIDTH-1:0] coord_i,
  output digit_status_t          status_o,
  output logic [DIGIT_BITS-1:0]  digit_o
);

  localparam int unsigned NUM_DIGITS = (COORD_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;
  localparam int unsigned MAG_WIDTH  = NUM_DIGITS * DIGIT_BITS;
  localparam int unsigned CNT_WIDTH  = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [CNT_WIDTH-1:0] LAST_CNT = CNT_WIDTH'(NUM_DIGITS - 1);

  logic [MAG_WIDTH-1:0]   mag_q, mag_d;
  logic [CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic                   neg_q, neg_d;
  logic [COORD_WIDTH-1:0] abs_val;
  logic                   coord_neg;
  logic                   last_digit;
  logic                   top_zero;

  // Magnitude of the coordinate; the most negative value wraps to itself,
  // which read unsigned is the right magnitude.
  assign coord_neg = coord_i[COORD_WIDTH-1];
  assign abs_val   = coord_neg ? (~coord_i + 1'b1) : coord_i;

  assign digit_o    = mag_q[MAG_WIDTH-1 -: DIGIT_BITS];
  assign top_zero   = (digit_o == '0);
  assign last_digit = (cnt_q == LAST_CNT);

  assign status_o.neg        = neg_q;
  assign status_o.skip_more  = top_zero && !last_digit;
  assign status_o.digit_more = !last_digit;

  // Load, then shift one digit per digit step, and per skip step while the top digit is zero and not the last.
  always_comb begin
    mag_d = mag_q;
    cnt_d = cnt_q;
    neg_d = neg_q;
    case (op_i)
      OP_LOAD: begin
        mag_d = MAG_WIDTH'(abs_val);
        cnt_d = '0;
        neg_d = coord_neg;
      end
      OP_SKIP: begin
        if (top_zero && !last_digit) begin
          mag_d = {mag_q[MAG_WIDTH-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_DIGIT: begin
        mag_d = {mag_q[MAG_WIDTH-DIGIT_BITS-1:0], {DIGIT_BITS{1'b0}}};
        cnt_d = cnt_q + 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      neg_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      neg_q <= neg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q <= mag_d;
  end

endmodule

// ===== hw/rtl/line_segment_base32_text_encoder.sv =====
// ----------------------------------------------------------------------------
// line_segment_base32_text_encoder
// Writes a line segment as text: four signed base 32 numbers and a comma.
// ----------------------------------------------------------------------------
// Usage: a segment word (start_x, start_y, end_x, end_y) is taken on in_if
// when valid and ready are both high; ready is high only while the sequencer
// waits at its idle step. The text leaves on out_if one character per word:
// an optional '-', the digits 0-9 and a-v without leading zeros, a space
// between numbers, and a closing ',' that carries last_char.
// A small control store steps the work; with D = ceil(COORD_WIDTH/5) digit
// slots each number runs through a load, a sign test, a '-' step when
// negative, D + 1 skip or digit steps, a separator test and a space or comma,
// and the idle step takes the next segment. The first character comes from
// the minus step when the first number is negative, otherwise from the first
// digit step once leading zeros are skipped.
// One output register holds the current character; when the receiver stalls,
// the step that would send the next character waits, and the sequencer
// stops with it. After the comma is sent the next segment may be accepted
// while the comma still waits. Reset returns the sequencer to idle and
// empties the output register.
// ----------------------------------------------------------------------------
module line_segment_base32_text_encoder
  import lsb32_pkg::*;
#(
  parameter int unsigned COORD_WIDTH = 32
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  lsb32_seg_if.sink    in_if,
  lsb32_char_if.source out_if
);

  step_t                                   pc_q, pc_d;
  logic [1:0]                              idx_q, idx_d;
  logic [NUM_COORDS-1:0][COORD_WIDTH-1:0] coord_q;
  logic                                    out_valid_q, out_valid_d;
  logic [7:0]                              out_char_q, out_char_d;
  logic                                    out_last_q, out_last_d;

  ucode_t                  ctl;
  logic                    cond_true;
  logic                    out_free;
  logic                    advance;
  logic                    in_accept;
  op_e                     unit_op;
  digit_status_t           status;
  logic [DIGIT_BITS-1:0]   digit;
  logic [7:0]              emit_char;

  // Fetch and handshake.
  assign ctl       = ucode_rom(pc_q);
  assign in_if.ready = (pc_q == STEP_IDLE);
  assign in_accept = in_if.valid && in_if.ready;
  assign out_free  = !out_valid_q || out_if.ready;
  assign advance   = (ctl.emit == EMIT_NONE) || out_free;
  assign unit_op   = advance ? ctl.op : OP_NONE;

  // Jump condition of the current step.
  always_comb begin
    unique case (ctl.cond)
      COND_NEVER:      cond_true = 1'b0;
      COND_ALWAYS:     cond_true = 1'b1;
      COND_NO_INPUT:   cond_true = !in_if.valid;
      COND_POSITIVE:   cond_true = !status.neg;
      COND_SKIP_MORE:  cond_true = status.skip_more;
      COND_DIGIT_MORE: cond_true = status.digit_more;
      COND_LAST_COORD: cond_true = (idx_q == 2'(NUM_COORDS - 1));
      default:         cond_true = 1'b1;
    endcase
  end

  // Step counter and coordinate index.
  always_comb begin
    pc_d  = pc_q;
    idx_d = idx_q;
    if (advance) begin
      pc_d = cond_true ? ctl.target : pc_q + 1'b1;
      if (unit_op == OP_NEXT) begin
        idx_d = idx_q + 1'b1;
      end
      if (in_accept) begin
        idx_d = '0;
      end
    end
  end

  // Character chosen by the current step.
  always_comb begin
    unique case (ctl.emit)
      EMIT_MINUS: emit_char = CHAR_MINUS;
      EMIT_DIGIT: emit_char = digit_char(digit);
      EMIT_SPACE: emit_char = CHAR_SPACE;
      EMIT_COMMA: emit_char = CHAR_COMMA;
      default:    emit_char = CHAR_SPACE;
    endcase
  end

  // Output register.
  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (out_valid_q && out_if.ready) begin
      out_valid_d = 1'b0;
    end
    if (advance && (ctl.emit != EMIT_NONE)) begin
      out_valid_d = 1'b1;
      out_char_d  = emit_char;
      out_last_d  = (ctl.emit == EMIT_COMMA);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_IDLE;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
    if (in_accept) begin
      coord_q[0] <= in_if.start_x;
      coord_q[1] <= in_if.start_y;
      coord_q[2] <= in_if.end_x;
      coord_q[3] <= in_if.end_y;
    end
  end

  lsb32_digit_unit #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_digit_unit (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .op_i    (unit_op),
    .coord_i (coord_q[idx_q]),
    .status_o(status),
    .digit_o (digit)
  );

  assign out_if.valid     = out_valid_q;
  assign out_if.text_char = out_char_q;
  assign out_if.last_char = out_last_q;

endmodule

// ===== hw/rtl/lsb32_checker.sv =====
// ----------------------------------------------------------------------------
// lsb32_checker
// Port-level checks of the segment text encoder, bound to the top level.
// ----------------------------------------------------------------------------
module lsb32_checker
  import lsb32_pkg::*;
(
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] text_char_i,
  input logic       last_char_i
);

  // A character word that is not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("character word dropped while stalled");

  // Once a segment is taken the encoder is busy with it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("new segment taken while one is in progress");

  // The last mark sits on the comma and only there.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (last_char_i == (text_char_i == CHAR_COMMA)))
    else $error("last mark and comma disagree");

  // While the encoder waits for a segment, only the comma can still be pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> last_char_i)
    else $error("idle with a character other than the comma pending");

endmodule

bind line_segment_base32_text_encoder lsb32_checker u_lsb32_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_if.valid),
  .in_ready_i (in_if.ready),
  .out_valid_i(out_if.valid),
  .out_ready_i(out_if.ready),
  .text_char_i(out_if.text_char),
  .last_char_i(out_if.last_char)
);

// ===== sim/line_segment_base32_text_encoder_test.sv =====
// ----------------------------------------------------------------------------
// line_segment_base32_text_encoder_test
// Self-checking bench for the segment text encoder. Segment words go in on a
// valid/ready channel with random gaps. Each accepted word is turned into the
// expected character sequence by a local base 32 formatter. Character words
// leave under random receiver stalls and are checked in order against it.
// ----------------------------------------------------------------------------
module line_segment_base32_text_encoder_test
  import lsb32_pkg::*;
();

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned IDLE_PERCENT = 24;
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned DRAIN_CYCLES = 64;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;

  // One expected character word.
  typedef struct packed {
    logic [7:0] text;
    logic       last;
  } char_word_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  lsb32_seg_if #(.COORD_WIDTH(COORD_WIDTH)) seg_bus ();
  lsb32_char_if char_bus ();

  line_segment_base32_text_encoder #(
    .COORD_WIDTH(COORD_WIDTH)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (seg_bus),
    .out_if (char_bus)
  );

  string      digit_set = "0123456789abcdefghijklmnopqrstuv";
  char_word_t expected_text[$];
  int         mismatches = 0;
  bit         idling_on = 1'b1;

  // Clock with a period of 10.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Appends the text form of one coordinate to the expected characters.
  function automatic void format_coord(input coord_t coord);
    logic [COORD_WIDTH-1:0] magnitude;
    logic [4:0]             digits[8];
    int                     count;
    count = 0;
    if (coord < 0) begin
      expected_text.push_back('{text: CHAR_MINUS, last: 1'b0});
      magnitude = -coord;
    end else begin
      magnitude = coord;
    end
    // Collect digits least significant first; zero still yields one digit.
    do begin
      digits[count] = magnitude[4:0];
      count++;
      magnitude = magnitude >> 5;
    end while (magnitude != 0);
    for (int k = count - 1; k >= 0; k--) begin
      expected_text.push_back('{text: digit_set[digits[k]], last: 1'b0});
    end
  endfunction

  // Appends the whole text of one segment: four numbers, spaces, a comma.
  function automatic void format_segment(input coord_t sx, input coord_t sy,
                                         input coord_t ex, input coord_t ey);
    format_coord(sx);
    expected_text.push_back('{text: CHAR_SPACE, last: 1'b0});
    format_coord(sy);
    expected_text.push_back('{text: CHAR_SPACE, last: 1'b0});
    format_coord(ex);
    expected_text.push_back('{text: CHAR_SPACE, last: 1'b0});
    format_coord(ey);
    expected_text.push_back('{text: CHAR_COMMA, last: 1'b1});
  endfunction

  // Random coordinate, biased toward digit-count boundaries and extremes.
  function automatic coord_t random_coord();
    coord_t value;
    int     shift;
    case ($urandom_range(3))
      0: value = $urandom;
      1: value = $signed($urandom_range(63)) - 32;
      2: begin
        shift = 5 * $urandom_range(1, 6);
        value = (coord_t'(1) <<< shift) + $signed($urandom_range(2)) - 1;
        if ($urandom_range(1) == 1) begin
          value = -value;
        end
      end
      default: begin
        case ($urandom_range(3))
          0: value = {1'b1, {(COORD_WIDTH-1){1'b0}}};
          1: value = {1'b0, {(COORD_WIDTH-1){1'b1}}};
          2: value = '0;
          default: value = '1;
        endcase
      end
    endcase
    return value;
  endfunction

  // Offers one segment word, waits for its accept and formats its text.
  task automatic send_segment(input coord_t sx, input coord_t sy,
                              input coord_t ex, input coord_t ey);
    while (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
      seg_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    seg_bus.valid   <= 1'b1;
    seg_bus.start_x <= sx;
    seg_bus.start_y <= sy;
    seg_bus.end_x   <= ex;
    seg_bus.end_y   <= ey;
    do begin
      @(posedge clk_i);
    end while (!seg_bus.ready);
    format_segment(sx, sy, ex, ey);
  endtask

  // Zero, one digit, both ends of the range and the most negative value.
  task automatic test_extremes();
    send_segment(0, 0, 0, 0);
    send_segment(32'sh7FFF_FFFF, 32'sh8000_0000, -1, 1);
    send_segment(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);
    send_segment(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_segment(-1, -1, -1, -1);
    send_segment(31, 32, -31, -32);
    send_segment(1023, 1024, -1024, -1023);
    send_segment(32'sh4000_0000, 32'sh3FFF_FFFF, -32'sh4000_0000, 32'sh8000_0001);
  endtask

  // Every digit character, both signs, one digit per number.
  task automatic test_digit_set();
    for (int k = 0; k < 8; k++) begin
      send_segment(4 * k, -(4 * k + 1), 4 * k + 2, -(4 * k + 3));
    end
  endtask

  // Random segments with the receiver and sender never idling.
  task automatic test_back_to_back(input int count);
    idling_on = 1'b0;
    repeat (count) begin
      send_segment(random_coord(), random_coord(), random_coord(), random_coord());
    end
    idling_on = 1'b1;
  endtask

  // Random segments with random gaps on both sides.
  task automatic test_random_traffic(input int count);
    repeat (count) begin
      send_segment(random_coord(), random_coord(), random_coord(), random_coord());
    end
  endtask

  // Receiver stalls at random while idling is on.
  initial begin
    char_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (idling_on && $urandom_range(99) < IDLE_PERCENT) begin
        char_bus.ready <= 1'b0;
      end else begin
        char_bus.ready <= 1'b1;
      end
    end
  end

  // Compares each accepted character word with the oldest expectation.
  always @(posedge clk_i) begin : check_text
    char_word_t want;
    if (rst_ni && char_bus.valid && char_bus.ready) begin
      if (expected_text.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: unexpected word %h last %b", $realtime,
                   char_bus.text_char, char_bus.last_char);
        end
      end else begin
        want = expected_text.pop_front();
        if (char_bus.text_char !== want.text || char_bus.last_char !== want.last) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("%0t: expected %h last %b, got %h last %b", $realtime,
                     want.text, want.last, char_bus.text_char, char_bus.last_char);
          end
        end
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  // Main sequence.
  initial begin
    rst_ni           = 1'b0;
    seg_bus.valid    = 1'b0;
    seg_bus.start_x  = '0;
    seg_bus.start_y  = '0;
    seg_bus.end_x    = '0;
    seg_bus.end_y    = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_extremes();
    test_digit_set();
    test_random_traffic(60);
    test_back_to_back(30);
    test_random_traffic(90);
    seg_bus.valid <= 1'b0;

    while (expected_text.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0 && expected_text.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/lsb32_pkg.sv
hw/rtl/lsb32_if.sv
hw/rtl/lsb32_digit_unit.sv
hw/rtl/line_segment_base32_text_encoder.sv
hw/rtl/lsb32_checker.sv
sim/line_segment_base32_text_encoder_test.sv
